/* sv/arx4_pkg.sv */
// shared types, constants and mixing function for the four-word arx cipher unit
package arx4_pkg;

  localparam int WORD_W = 32;
  localparam int BLOCK_WORDS = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int ROUND_COUNT_DEFAULT = 3;
  localparam int PERMS_PER_ROUND_DEFAULT = 2;

  localparam logic [CFG_IDX_W-1:0] KEY_WORD0_IDX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] KEY_WORD1_IDX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] KEY_WORD2_IDX = 2'd2;
  localparam logic [CFG_IDX_W-1:0] KEY_WORD3_IDX = 2'd3;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [BLOCK_WORDS-1:0][WORD_W-1:0] block_t;

  typedef struct packed {
    word_t plain_a;
    word_t plain_b;
    word_t plain_c;
    word_t plain_d;
  } plain_t;

  typedef struct packed {
    word_t cipher_a;
    word_t cipher_b;
    word_t cipher_c;
    word_t cipher_d;
  } cipher_t;

  // rotation pair of the mixing step for each word position
  localparam logic [4:0] ROT_FIRST  [0:3] = '{5'd1, 5'd2, 5'd3, 5'd5};
  localparam logic [4:0] ROT_SECOND [0:3] = '{5'd11, 5'd7, 5'd15, 5'd17};

  function automatic word_t rotl32(input word_t x, input logic [4:0] r);
    logic [2*WORD_W-1:0] dbl;
    dbl = {x, x} << r;
    return dbl[2*WORD_W-1:WORD_W];
  endfunction

  function automatic word_t mix_step(input word_t x, input word_t y, input word_t z,
                                     input word_t w, input logic [4:0] r1,
                                     input logic [4:0] r2);
    word_t t;
    t = x + (y ^ z ^ w);
    t = rotl32(t, r1);
    t = t ^ (w ^ (y & (z ^ w)));
    return rotl32(t, r2);
  endfunction

endpackage

/* sv/arx_block_cipher_4x32_encrypt_unit.sv */
// Four-word arx block cipher, encryption direction: accepts one 128-bit block per cycle
// while in_stall is low, and returns its ciphertext through the input register and a
// pipeline of one mixing step per stage. The round keys are held in registers and are
// rebuilt by a sequencer that does one mixing step per cycle; after reset and after every
// key write it runs through its load and run states, during which in_stall is high. A
// stall on the output while the last stage holds a block freezes the whole pipeline
// without losing or repeating a block.
module arx_block_cipher_4x32_encrypt_unit
  import arx4_pkg::*;
#(
  parameter int ROUND_COUNT = ROUND_COUNT_DEFAULT,
  parameter int PERMS_PER_ROUND = PERMS_PER_ROUND_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  plain_t                in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output cipher_t               out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int STAGES = BLOCK_WORDS * ROUND_COUNT * PERMS_PER_ROUND;
  localparam int STEPS_PER_ROUND = BLOCK_WORDS * PERMS_PER_ROUND;
  localparam int ROUND_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_LOAD,
    SEQ_RUN
  } seq_state_t;

  // key registers
  block_t key;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        KEY_WORD0_IDX: key[0] <= cfg_data[WORD_W-1:0];
        KEY_WORD1_IDX: key[1] <= cfg_data[WORD_W-1:0];
        KEY_WORD2_IDX: key[2] <= cfg_data[WORD_W-1:0];
        KEY_WORD3_IDX: key[3] <= cfg_data[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // key schedule sequencer
  seq_state_t       seq_state;
  block_t           sched;
  block_t           sched_next;
  block_t           rks [ROUND_COUNT];
  logic [1:0]       word_idx;
  logic [ROUND_W-1:0] round_idx;

  always_comb begin
    sched_next = sched;
    sched_next[word_idx] = mix_step(sched[word_idx], sched[word_idx + 2'd1],
                                    sched[word_idx + 2'd2], sched[word_idx + 2'd3],
                                    ROT_FIRST[word_idx], ROT_SECOND[word_idx]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state <= SEQ_LOAD;
      word_idx  <= '0;
      round_idx <= '0;
    end else if (cfg_we) begin
      seq_state <= SEQ_LOAD;
    end else begin
      unique case (seq_state)
        SEQ_IDLE: ;
        SEQ_LOAD: begin
          sched     <= key;
          word_idx  <= '0;
          round_idx <= '0;
          seq_state <= SEQ_RUN;
        end
        SEQ_RUN: begin
          sched    <= sched_next;
          word_idx <= word_idx + 2'd1;
          if (word_idx == 2'd3) begin
            rks[round_idx] <= sched_next ^ key;
            round_idx      <= round_idx + ROUND_W'(1);
            if (round_idx == ROUND_W'(ROUND_COUNT - 1)) begin
              seq_state <= SEQ_IDLE;
            end
          end
        end
        default: seq_state <= SEQ_LOAD;
      endcase
    end
  end

  // data pipeline
  block_t pipe  [0:STAGES];
  logic   valid [0:STAGES];
  logic   adv;

  assign adv      = !valid[STAGES] || !out_stall;
  assign in_stall = !adv || (seq_state != SEQ_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (adv) begin
      valid[0] <= in_valid && (seq_state == SEQ_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe[0][0] <= in_data.plain_a;
      pipe[0][1] <= in_data.plain_b;
      pipe[0][2] <= in_data.plain_c;
      pipe[0][3] <= in_data.plain_d;
    end
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    localparam int W = k % BLOCK_WORDS;
    localparam int R = k / STEPS_PER_ROUND;
    localparam bit ADD_KEY = (k % STEPS_PER_ROUND) == 0;

    block_t blk_in;
    block_t blk_out;

    always_comb begin
      blk_in = pipe[k];
      if (ADD_KEY) begin
        blk_in = pipe[k] ^ rks[R];
      end
      blk_out = blk_in;
      blk_out[W] = mix_step(blk_in[W], blk_in[(W + 1) % BLOCK_WORDS],
                            blk_in[(W + 2) % BLOCK_WORDS], blk_in[(W + 3) % BLOCK_WORDS],
                            ROT_FIRST[W], ROT_SECOND[W]);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else if (adv) begin
        valid[k+1] <= valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pipe[k+1] <= blk_out;
      end
    end
  end

  // final whitening with round key 0
  block_t fin;

  assign fin       = pipe[STAGES] ^ rks[0];
  assign out_valid = valid[STAGES];

  always_comb begin
    out_data.cipher_a = fin[0];
    out_data.cipher_b = fin[1];
    out_data.cipher_c = fin[2];
    out_data.cipher_d = fin[3];
  end

endmodule

/* dv/tb_arx_block_cipher_4x32_encrypt_unit.sv */
// self-checking testbench for the arx cipher unit: directed table, then random blocks under fixed and random keys
`timescale 1ns / 100ps

module tb_arx_block_cipher_4x32_encrypt_unit;
  import arx4_pkg::*;

  localparam int ROUNDS = 3;
  localparam int PERMS = 2;
  localparam int PIPE_LATENCY = 4 * ROUNDS * PERMS + 1;
  localparam int DRAIN_CYCLES = 2 * PIPE_LATENCY;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER_BLOCKS = 400;
  localparam int RANDOM_PHASES = 8;
  localparam int BLOCKS_PER_PHASE = 155;
  localparam int DIRECTED_ROWS = 13;

  localparam logic [CFG_IDX_W-1:0] KEY_IDX [4] = '{
    KEY_WORD0_IDX, KEY_WORD1_IDX, KEY_WORD2_IDX, KEY_WORD3_IDX
  };

  typedef struct packed {
    plain_t  blk;
    logic    known;
    cipher_t known_cipher;
  } vector_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  plain_t                in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  cipher_t               out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = KEY_WORD0_IDX;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cipher_t pending_cipher [$];
  cipher_t want;
  block_t  key_copy = '0;
  int      fail_count = 0;
  int      blocks_sent = 0;
  int      burst_left = 0;
  int      idle_cycles = 0;
  bit      held = 1'b0;

  // only the all-zero row under the reset key has a ciphertext known by inspection
  vector_t directed_rows [DIRECTED_ROWS] = '{
    '{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b1,
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}},
    '{'{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff}, 1'b0, '0},
    '{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b0, '0},
    '{'{32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001}, 1'b0, '0},
    '{'{32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555}, 1'b0, '0},
    '{'{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa}, 1'b0, '0},
    '{'{32'hffff_ffff, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0, '0},
    '{'{32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0000}, 1'b0, '0},
    '{'{32'h0000_0000, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0000}, 1'b0, '0},
    '{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hffff_ffff}, 1'b0, '0},
    '{'{32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000}, 1'b0, '0},
    '{'{32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210}, 1'b0, '0},
    '{'{32'hdead_beef, 32'h0bad_f00d, 32'hcafe_babe, 32'h1357_9bdf}, 1'b0, '0}
  };

  arx_block_cipher_4x32_encrypt_unit #(
    .ROUND_COUNT(ROUNDS),
    .PERMS_PER_ROUND(PERMS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic word_t rot_left(input word_t x, input int unsigned r);
    return (x << r) | (x >> (WORD_W - r));
  endfunction

  function automatic word_t arx_mix(input word_t x, input word_t y, input word_t z,
                                    input word_t w, input int unsigned r1,
                                    input int unsigned r2);
    word_t t;
    t = x + (y ^ z ^ w);
    t = rot_left(t, r1);
    t = t ^ w ^ (y & (z ^ w));
    return rot_left(t, r2);
  endfunction

  function automatic block_t arx_permute(input block_t v);
    v[0] = arx_mix(v[0], v[1], v[2], v[3], 1, 11);
    v[1] = arx_mix(v[1], v[2], v[3], v[0], 2, 7);
    v[2] = arx_mix(v[2], v[3], v[0], v[1], 3, 15);
    v[3] = arx_mix(v[3], v[0], v[1], v[2], 5, 17);
    return v;
  endfunction

  function automatic cipher_t encrypt_block(input plain_t blk, input block_t key);
    block_t  sched;
    block_t  sub_key [ROUNDS];
    block_t  v;
    cipher_t c;
    sched = key;
    for (int i = 0; i < ROUNDS; i++) begin
      sched = arx_permute(sched);
      sub_key[i] = sched ^ key;
    end
    v = {blk.plain_d, blk.plain_c, blk.plain_b, blk.plain_a};
    for (int i = 0; i < ROUNDS; i++) begin
      v = v ^ sub_key[i];
      for (int p = 0; p < PERMS; p++) begin
        v = arx_permute(v);
      end
    end
    v = v ^ sub_key[0];
    c.cipher_a = v[0];
    c.cipher_b = v[1];
    c.cipher_c = v[2];
    c.cipher_d = v[3];
    return c;
  endfunction

  // mostly uniform, with some all-zero, all-one and one-hot words
  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return word_t'(1) << $urandom_range(0, WORD_W - 1);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_block(input plain_t blk, input logic known, input cipher_t known_cipher);
    in_valid <= 1'b1;
    in_data <= blk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_cipher.push_back(known ? known_cipher : encrypt_block(blk, key_copy));
    blocks_sent++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(0, 40);
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_key(input block_t key, input logic [3:0] mask);
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        cfg_we <= 1'b1;
        cfg_index <= KEY_IDX[i];
        cfg_data <= key[i];
        @(posedge clk);
        key_copy[i] = key[i];
      end
    end
    cfg_we <= 1'b0;
  endtask

  task automatic drain_blocks();
    if (in_valid) in_valid <= 1'b0;
    while (pending_cipher.size() != 0) @(posedge clk);
  endtask

  initial begin
    block_t     next_key;
    logic [3:0] mask;
    plain_t     blk;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    burst_left = $urandom_range(0, 40);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_block(directed_rows[r].blk, directed_rows[r].known, directed_rows[r].known_cipher);
    end
    drain_blocks();

    for (int ph = 1; ph <= RANDOM_PHASES; ph++) begin
      mask = 4'hf;
      case (ph)
        1: next_key = '1;
        2: next_key = '0;
        3: next_key = {32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa};
        4: next_key = {32'h0000_0001, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000};
        default: begin
          next_key = {rand_word(), rand_word(), rand_word(), rand_word()};
          mask = 4'($urandom_range(1, 15));
        end
      endcase
      write_key(next_key, mask);
      for (int n = 0; n < BLOCKS_PER_PHASE; n++) begin
        blk.plain_a = rand_word();
        blk.plain_b = rand_word();
        blk.plain_c = rand_word();
        blk.plain_d = rand_word();
        send_block(blk, 1'b0, '0);
      end
      drain_blocks();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_cipher.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // receiver: random stall patterns, plus one long hold-off to back up the pipeline
  initial begin
    int mode;
    int len;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && blocks_sent >= HOLD_AFTER_BLOCKS) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      len = $urandom_range(10, 120);
      for (int k = 0; k < len; k++) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= k[0];
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_cipher.size() == 0) begin
        $error("ciphertext with no block outstanding: %h", out_data);
        fail_count++;
      end else begin
        want = pending_cipher.pop_front();
        if (out_data.cipher_a !== want.cipher_a) begin
          $error("cipher_a: expected %h, actual %h", want.cipher_a, out_data.cipher_a);
          fail_count++;
        end
        if (out_data.cipher_b !== want.cipher_b) begin
          $error("cipher_b: expected %h, actual %h", want.cipher_b, out_data.cipher_b);
          fail_count++;
        end
        if (out_data.cipher_c !== want.cipher_c) begin
          $error("cipher_c: expected %h, actual %h", want.cipher_c, out_data.cipher_c);
          fail_count++;
        end
        if (out_data.cipher_d !== want.cipher_d) begin
          $error("cipher_d: expected %h, actual %h", want.cipher_d, out_data.cipher_d);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Verification failed");
    $finish;
  end

endmodule
